>>> rtl/circular_deque_defines.svh
// Assertion macros shared by the deque checker.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Clocked assertion, inactive while reset is high.
`define CDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cdq_pkg.sv
// Types and codes for the circular deque.
package cdq_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DENIED    = 2'd3
  } status_t;

  localparam logic MODE_IN_RESTRICT  = 1'b0;  // no push front
  localparam logic MODE_OUT_RESTRICT = 1'b1;  // no pop back

  localparam int WORD_W = 32;
  localparam int FILL_W = 4;

  typedef struct packed {
    req_t                     req_type;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    status_t                  status;
    logic [FILL_W-1:0]        fill_level;
  } out_t;

endpackage

>>> rtl/circular_deque.sv
// Circular deque: one request in, one result out, valid in the cycle after accept.
// Throughput is one request per clock while no result stalls; indices and count update in
// the accept cycle, and the popped word comes from the entry RAM's registered read port
// in the cycle after. A stalled result holds the input side off until it is taken.
// Synchronous reset empties the deque, clears the mode to input restricted and drops
// the result; entry contents are not cleared.
module circular_deque #(
  parameter int DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  cdq_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output cdq_pkg::out_t out_data
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] front_idx, front_idx_next;
  logic [AW-1:0] back_idx, back_idx_next;
  logic [CW-1:0] count, count_next;
  logic          restrict_mode;

  logic          res_pop;
  status_t       res_status;
  logic [FILL_W-1:0] res_fill;

  logic          accept;
  req_t          req;
  logic          is_push;
  logic          denied;
  status_t       status_now;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign req      = in_data.req_type;
  assign is_push  = (req == REQ_PUSH_BACK) || (req == REQ_PUSH_FRONT);
  assign denied   = (restrict_mode == MODE_IN_RESTRICT && req == REQ_PUSH_FRONT) ||
                    (restrict_mode == MODE_OUT_RESTRICT && req == REQ_POP_BACK);

  assign front_inc = (front_idx == LAST) ? '0 : front_idx + 1'b1;
  assign front_dec = (front_idx == '0) ? LAST : front_idx - 1'b1;
  assign back_inc  = (back_idx == LAST) ? '0 : back_idx + 1'b1;
  assign back_dec  = (back_idx == '0) ? LAST : back_idx - 1'b1;

  // Mode check wins over full/empty.
  always_comb begin
    priority if (denied) begin
      status_now = ST_DENIED;
    end else if (is_push && count == CW'(DEPTH)) begin
      status_now = ST_OVERFLOW;
    end else if (!is_push && count == '0) begin
      status_now = ST_UNDERFLOW;
    end else begin
      status_now = ST_OK;
    end
  end

  always_comb begin
    front_idx_next = front_idx;
    back_idx_next  = back_idx;
    count_next     = count;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = back_idx;
    ram_raddr      = front_idx;
    if (accept && status_now == ST_OK) begin
      unique case (req)
        REQ_PUSH_BACK: begin
          ram_we        = 1'b1;
          ram_waddr     = back_idx;
          back_idx_next = back_inc;
          count_next    = count + 1'b1;
        end
        REQ_PUSH_FRONT: begin
          ram_we         = 1'b1;
          ram_waddr      = front_dec;
          front_idx_next = front_dec;
          count_next     = count + 1'b1;
        end
        REQ_POP_FRONT: begin
          ram_re         = 1'b1;
          ram_raddr      = front_idx;
          front_idx_next = front_inc;
          count_next     = count - 1'b1;
        end
        REQ_POP_BACK: begin
          ram_re        = 1'b1;
          ram_raddr     = back_dec;
          back_idx_next = back_dec;
          count_next    = count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx     <= '0;
      back_idx      <= '0;
      count         <= '0;
      restrict_mode <= MODE_IN_RESTRICT;
      out_valid     <= 1'b0;
    end else begin
      front_idx <= front_idx_next;
      back_idx  <= back_idx_next;
      count     <= count_next;
      if (cfg_we) begin
        restrict_mode <= cfg_data;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result fields; the popped word arrives from the RAM read register.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_pop    <= ram_re;
      res_status <= status_now;
      res_fill   <= FILL_W'(count_next);
    end
  end

  cdq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_data.pop_value  = res_pop ? ram_rdata : '0;
  assign out_data.status     = res_status;
  assign out_data.fill_level = res_fill;

endmodule

>>> rtl/cdq_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module cdq_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cdq_checker.sv
// Port-level checks for the circular deque, bound to the top level.
`include "circular_deque_defines.svh"

module cdq_checker #(
  parameter int DEPTH = 8
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input cdq_pkg::out_t out_data
);
  import cdq_pkg::*;

  `CDQ_ASSERT_ALWAYS(a_no_result_after_rst, rst |=> !out_valid, "result valid after reset")
  `CDQ_ASSERT(a_result_held, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `CDQ_ASSERT(a_zero_when_failed, out_valid && out_data.status != ST_OK |-> out_data.pop_value == '0, "failed request returned a word")
  `CDQ_ASSERT(a_fill_bound, out_valid |-> (DEPTH > 15) || (out_data.fill_level <= FILL_W'(DEPTH)), "fill level beyond depth")
  `CDQ_ASSERT(a_request_gives_result, in_valid && !in_stall |=> out_valid, "accepted request gave no result")

endmodule

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);

>>> tb/tb_circular_deque.sv
// Testbench for circular_deque: random and directed requests checked against a deque model.
import cdq_pkg::*;

class deque_scoreboard #(int DEPTH = 8);
  logic signed [WORD_W-1:0] slots[DEPTH];
  int front_pos;
  int back_pos;
  int held;
  logic mode;
  out_t expected_q[$];
  int errors;
  int checked;
  int status_count[4];

  function new();
    front_pos = 0;
    back_pos = 0;
    held = 0;
    mode = MODE_IN_RESTRICT;
    errors = 0;
    checked = 0;
    foreach (status_count[i]) status_count[i] = 0;
  endfunction

  function void set_mode(logic m);
    mode = m;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Apply one accepted request to the model and queue the result it must produce.
  function void note_request(in_t req);
    out_t r;
    bit is_push;
    r = '0;
    r.status = ST_OK;
    is_push = (req.req_type == REQ_PUSH_BACK) || (req.req_type == REQ_PUSH_FRONT);
    // mode is checked before fullness or emptiness
    if ((mode == MODE_IN_RESTRICT && req.req_type == REQ_PUSH_FRONT) ||
        (mode == MODE_OUT_RESTRICT && req.req_type == REQ_POP_BACK)) begin
      r.status = ST_DENIED;
    end else if (is_push && held >= DEPTH) begin
      r.status = ST_OVERFLOW;
    end else if (!is_push && held == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      case (req.req_type)
        REQ_PUSH_BACK: begin
          slots[back_pos] = req.push_value;
          back_pos = (back_pos + 1) % DEPTH;
          held++;
        end
        REQ_PUSH_FRONT: begin
          front_pos = (front_pos + DEPTH - 1) % DEPTH;
          slots[front_pos] = req.push_value;
          held++;
        end
        REQ_POP_FRONT: begin
          r.pop_value = slots[front_pos];
          front_pos = (front_pos + 1) % DEPTH;
          held--;
        end
        default: begin
          back_pos = (back_pos + DEPTH - 1) % DEPTH;
          r.pop_value = slots[back_pos];
          held--;
        end
      endcase
    end
    r.fill_level = FILL_W'(held);
    status_count[r.status]++;
    expected_q.push_back(r);
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 30) $display("MISMATCH: %s", msg);
  endtask

  task check_result(out_t got);
    out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with no request pending: pop %0d status %0d fill %0d",
                                got.pop_value, got.status, got.fill_level));
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.pop_value !== want.pop_value)
      report_mismatch($sformatf("result %0d: pop_value %0d, want %0d",
                                checked, got.pop_value, want.pop_value));
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                checked, got.status, want.status));
    if (got.fill_level !== want.fill_level)
      report_mismatch($sformatf("result %0d: fill_level %0d, want %0d",
                                checked, got.fill_level, want.fill_level));
  endtask
endclass

module tb_circular_deque;
  localparam int DEPTH = 8;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 287;
  localparam int CALM_ITEMS = 200;
  localparam int HOLD_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic signed [WORD_W-1:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] MAX_WORD = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic hold_off = 1'b0;  // asks the receiver for one long hold-off
  logic steady = 1'b0;    // receiver never stalls while set
  bit calm = 1'b0;        // sender never idles while set
  int quiet = 0;

  deque_scoreboard #(DEPTH) sb;

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
  task automatic offer(input req_t kind, input logic signed [WORD_W-1:0] value);
    in_t item;
    item.req_type = kind;
    item.push_value = value;
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(item);
  endtask

  task automatic write_mode(input logic m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(19))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic directed_in_restrict();
    offer(REQ_POP_FRONT, 0);
    offer(REQ_POP_BACK, 32'sh1234_5678);
    offer(REQ_PUSH_FRONT, 5);            // refused on an empty deque
    offer(REQ_PUSH_BACK, MIN_WORD);
    offer(REQ_PUSH_BACK, MAX_WORD);
    offer(REQ_PUSH_BACK, 0);
    offer(REQ_PUSH_BACK, -1);
    offer(REQ_PUSH_BACK, 1);
    offer(REQ_PUSH_BACK, 32'shaaaa_aaaa);
    offer(REQ_PUSH_BACK, 32'sh5555_5555);
    offer(REQ_PUSH_BACK, $urandom);
    offer(REQ_PUSH_BACK, 77);            // full
    offer(REQ_PUSH_FRONT, -7);           // refused, not overflow
    repeat (4) begin
      offer(REQ_POP_BACK, 0);
      offer(REQ_POP_FRONT, 0);
    end
  endtask

  task automatic directed_out_restrict();
    offer(REQ_POP_BACK, 0);              // refused on an empty deque
    offer(REQ_PUSH_FRONT, MIN_WORD);
    offer(REQ_PUSH_FRONT, MAX_WORD);
    offer(REQ_POP_BACK, 0);
    offer(REQ_POP_FRONT, -1);
    offer(REQ_POP_FRONT, 0);
  endtask

  // Runs that lean toward pushes or pops so the deque keeps reaching full and empty.
  task automatic random_requests(input int count, input logic m);
    int run_left;
    bit lean_push;
    int r;
    req_t kind;
    run_left = 0;
    lean_push = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        lean_push = 1'($urandom_range(1));
        run_left = $urandom_range(20, 6);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 6)
        kind = (m == MODE_IN_RESTRICT) ? REQ_PUSH_FRONT : REQ_POP_BACK;
      else if (r < (lean_push ? 70 : 36))
        kind = (m == MODE_IN_RESTRICT || $urandom_range(1)) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else
        kind = (m == MODE_OUT_RESTRICT || $urandom_range(1)) ? REQ_POP_FRONT : REQ_POP_BACK;
      offer(kind, pick_word());
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, no stalls while steady.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 37);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", quiet);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic phase_mode;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      phase_mode = p[0] ? MODE_OUT_RESTRICT : MODE_IN_RESTRICT;
      write_mode(phase_mode);
      case (p)
        0: directed_in_restrict();
        1: directed_out_restrict();
        2: hold_off <= 1'b1;
        3: begin
          calm = 1'b1;
          steady <= 1'b1;
          random_requests(CALM_ITEMS, phase_mode);
          calm = 1'b0;
          steady <= 1'b0;
        end
        default: ;
      endcase
      random_requests(RANDOM_PER_PHASE, phase_mode);
      in_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
    end
    $display("Covered %0d requests over %0d mode changes: %0d ok, %0d overflow, %0d underflow, %0d refused.",
             sb.checked, PHASES, sb.status_count[ST_OK], sb.status_count[ST_OVERFLOW],
             sb.status_count[ST_UNDERFLOW], sb.status_count[ST_DENIED]);
    $display("Included a %0d-cycle output hold-off that backed up the input side.", HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
